>>> rtl/core/lmp_pkg.sv
// Shared constants, types and elaboration-time tables for the lock-in magnitude/phase block.
package lmp_pkg;

  localparam int SUM_WIDTH     = 64;
  localparam int CORDIC_STAGES = 24;
  localparam int REF_AMPLITUDE = 16384;

  localparam int GAIN_W     = 18;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 18'd69649;
  localparam int ANG_W      = 42;      // degrees Q32, holds +-280 deg
  localparam int PH_W       = 25;      // degrees Q16 output
  localparam int MAG_W      = 32;
  localparam int NUM_SHIFT  = 29;      // numerator scale before the division
  localparam int KREF_W     = 48;      // k_q31 * REF_AMPLITUDE
  localparam int DEN_W      = KREF_W + 32;
  localparam int PROD_W     = 63 + GAIN_W;
  localparam int PHASE_LIMIT = 11796480;

  localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(64'd180 << 32);

  // atan(2^-i) in degrees Q32, same series and truncation as the fixed-point spec
  function automatic logic [63:0] atan_deg(input int stage);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] rad;
    int e;
    sum = '0;
    if (stage == 0) return 64'd45 << 32;
    for (int k = 0; k < 31; k++) begin
      e = 60 - stage * (2 * k + 1);
      if (e >= 0) begin
        term = (64'd1 << e) / 64'(2 * k + 1);
        sum = k[0] ? sum - term : sum + term;
      end
    end
    rad = sum >> 28;
    return (rad * 64'd3845054675) >> 26;
  endfunction

  // CORDIC gain in Q31: floor(sqrt(2^62 * prod(1 + 2^-2i)))
  function automatic logic [63:0] calc_k();
    logic [63:0] p;
    logic [63:0] res;
    logic [63:0] bitv;
    p = 64'd1 << 62;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (2 * i < 64) p = p + (p >> (2 * i));
    end
    res = '0;
    bitv = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (p >= res + bitv) begin
        p = p - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  localparam logic [63:0] K_Q31     = calc_k();
  localparam logic [63:0] KREF_FULL = K_Q31 * 64'(REF_AMPLITUDE);
  localparam logic [KREF_W-1:0] KREF = KREF_FULL[KREF_W-1:0];

  typedef struct packed {
    logic             cnt_err;
    logic             zero_vec;
    logic [DEN_W-1:0] den;
  } lmp_side_t;

  typedef struct packed {
    logic signed [63:0]      x;
    logic signed [63:0]      y;
    logic signed [ANG_W-1:0] z;
    lmp_side_t               side;
  } lmp_vec_t;

endpackage

>>> rtl/core/lmp_if.sv
// Word channel interfaces for the lock-in magnitude/phase block.
interface lmp_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] in_phase_sum;
  logic signed [63:0] quadrature_sum;
  logic [31:0]        sample_count;
  modport source (output valid, in_phase_sum, quadrature_sum, sample_count, input ready);
  modport sink   (input valid, in_phase_sum, quadrature_sum, sample_count, output ready);
endinterface

interface lmp_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        magnitude_volts;
  logic signed [24:0] phase_degrees;
  logic               count_error;
  logic               magnitude_saturated;
  modport source (output valid, magnitude_volts, phase_degrees, count_error,
                  magnitude_saturated, input ready);
  modport sink   (input valid, magnitude_volts, phase_degrees, count_error,
                  magnitude_saturated, output ready);
endinterface

>>> rtl/core/lmp_front.sv
// Input conditioning: sign extension, half-plane fold, and divisor product.
module lmp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic signed [63:0] in_phase_sum,
  input  logic signed [63:0] quadrature_sum,
  input  logic [31:0]        sample_count,
  output logic               out_valid,
  output lmp_pkg::lmp_vec_t  out_vec
);
  localparam int AW = lmp_pkg::ANG_W;

  logic signed [63:0] xs_ext, ys_ext, xs, ys;
  logic signed [63:0] x_fold, y_fold;
  logic signed [AW-1:0] z_init;

  logic               s1_valid;
  logic signed [63:0] s1_x, s1_y;
  logic signed [AW-1:0] s1_z;
  logic               s1_cnt_err, s1_zero;
  logic [63:0]        s1_pp_lo;
  logic [47:0]        s1_pp_hi;

  always_comb begin
    xs_ext = 64'(signed'(in_phase_sum[lmp_pkg::SUM_WIDTH-1:0]));
    ys_ext = 64'(signed'(quadrature_sum[lmp_pkg::SUM_WIDTH-1:0]));
    xs = xs_ext >>> 2;
    ys = ys_ext >>> 2;
    // left half-plane: rotate by 180 and preload the angle
    if (xs[63]) begin
      x_fold = -xs;
      y_fold = -ys;
      z_init = ys[63] ? -lmp_pkg::ANG_180 : lmp_pkg::ANG_180;
    end else begin
      x_fold = xs;
      y_fold = ys;
      z_init = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x       <= x_fold;
      s1_y       <= y_fold;
      s1_z       <= z_init;
      s1_cnt_err <= (sample_count == 32'd0);
      s1_zero    <= (xs == 64'sd0) && (ys == 64'sd0);
      s1_pp_lo   <= sample_count * lmp_pkg::KREF[31:0];
      s1_pp_hi   <= sample_count * lmp_pkg::KREF[lmp_pkg::KREF_W-1:32];
      out_vec.x             <= s1_x;
      out_vec.y             <= s1_y;
      out_vec.z             <= s1_z;
      out_vec.side.cnt_err  <= s1_cnt_err;
      out_vec.side.zero_vec <= s1_zero;
      out_vec.side.den      <= lmp_pkg::DEN_W'(s1_pp_lo) + {s1_pp_hi, 32'd0};
    end
  end
endmodule

>>> rtl/core/lmp_cordic.sv
// Vectoring CORDIC, one registered micro-rotation per stage.
module lmp_cordic (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  lmp_pkg::lmp_vec_t in_vec,
  output logic              out_valid,
  output lmp_pkg::lmp_vec_t out_vec
);
  localparam int N  = lmp_pkg::CORDIC_STAGES;
  localparam int AW = lmp_pkg::ANG_W;

  logic              stg_valid [0:N];
  lmp_pkg::lmp_vec_t stg       [0:N];

  assign stg_valid[0] = in_valid;
  assign stg[0]       = in_vec;

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [AW-1:0] ATAN_I = AW'(lmp_pkg::atan_deg(i));
    logic signed [63:0]   xc, yc, dx, dy;
    logic signed [AW-1:0] zc;
    lmp_pkg::lmp_vec_t    nxt;

    always_comb begin
      xc  = stg[i].x;
      yc  = stg[i].y;
      zc  = stg[i].z;
      dx  = yc >>> i;
      dy  = xc >>> i;
      nxt = stg[i];
      if (!yc[63]) begin
        nxt.x = xc + dx;
        nxt.y = yc - dy;
        nxt.z = zc + ATAN_I;
      end else begin
        nxt.x = xc - dx;
        nxt.y = yc + dy;
        nxt.z = zc - ATAN_I;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[i+1] <= 1'b0;
      end else if (adv) begin
        stg_valid[i+1] <= stg_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg[i+1] <= nxt;
      end
    end
  end

  assign out_valid = stg_valid[N];
  assign out_vec   = stg[N];
endmodule

>>> rtl/core/lmp_scale.sv
// Gain multiply, phase rounding, and restoring divider for the magnitude.
module lmp_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  lmp_pkg::lmp_vec_t           in_vec,
  input  logic [lmp_pkg::GAIN_W-1:0]  gain,
  output logic                        out_valid,
  output logic [31:0]                 magnitude_volts,
  output logic signed [24:0]          phase_degrees,
  output logic                        count_error,
  output logic                        magnitude_saturated
);
  localparam int AW   = lmp_pkg::ANG_W;
  localparam int DW   = lmp_pkg::DEN_W;
  localparam int PW   = lmp_pkg::PROD_W;
  localparam int MW   = lmp_pkg::MAG_W;
  localparam int KEEP = MW - lmp_pkg::NUM_SHIFT;   // product bits below the 2^32 line
  localparam int HW   = PW - KEEP;

  typedef struct packed {
    logic                             cnt_err;
    logic                             zero_vec;
    logic                             sat;
    logic [DW-1:0]                    den;
    logic signed [lmp_pkg::PH_W-1:0]  phase;
  } scl_tag_t;

  // M1: partial products and phase
  logic signed [AW-1:0] z_rnd;
  logic signed [AW-17:0] ph_wide;
  logic signed [lmp_pkg::PH_W-1:0] ph_clamp;
  logic [62:0] xf;

  logic                        m1_valid;
  logic [31+lmp_pkg::GAIN_W:0] m1_plo;
  logic [30+lmp_pkg::GAIN_W:0] m1_phi;
  scl_tag_t                    m1_tag;

  logic          m2_valid;
  logic [PW-1:0] m2_prod;
  scl_tag_t      m2_tag;

  logic [HW-1:0] m2_high;

  always_comb begin
    xf      = in_vec.x[62:0];
    z_rnd   = in_vec.z + AW'(32768);
    ph_wide = z_rnd[AW-1:16];
    if (ph_wide > (AW-16)'(lmp_pkg::PHASE_LIMIT)) begin
      ph_clamp = lmp_pkg::PH_W'(lmp_pkg::PHASE_LIMIT);
    end else if (ph_wide < -(AW-16)'(lmp_pkg::PHASE_LIMIT)) begin
      ph_clamp = -lmp_pkg::PH_W'(lmp_pkg::PHASE_LIMIT);
    end else begin
      ph_clamp = ph_wide[lmp_pkg::PH_W-1:0];
    end
  end

  assign m2_high = m2_prod[PW-1:KEEP];

  // divider stages
  logic          dv [0:MW];
  logic [DW-1:0] dr [0:MW];
  logic [MW-1:0] dl [0:MW];
  logic [MW-1:0] dq [0:MW];
  scl_tag_t      dt [0:MW];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      dv[0]    <= 1'b0;
    end else if (adv) begin
      m1_valid <= in_valid;
      m2_valid <= m1_valid;
      dv[0]    <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_plo           <= xf[31:0] * gain;
      m1_phi           <= xf[62:32] * gain;
      m1_tag.cnt_err   <= in_vec.side.cnt_err;
      m1_tag.zero_vec  <= in_vec.side.zero_vec;
      m1_tag.sat       <= 1'b0;
      m1_tag.den       <= in_vec.side.den;
      m1_tag.phase     <= ph_clamp;
      m2_prod          <= PW'(m1_plo) + {m1_phi, 32'd0};
      m2_tag           <= m1_tag;
      // quotient >= 2^32 exactly when numerator / 2^32 >= divisor
      dr[0]            <= DW'(m2_high);
      dl[0]            <= {m2_prod[KEEP-1:0], lmp_pkg::NUM_SHIFT'(0)};
      dq[0]            <= '0;
      dt[0]            <= {m2_tag.cnt_err, m2_tag.zero_vec, (DW'(m2_high) >= m2_tag.den),
                           m2_tag.den, m2_tag.phase};
    end
  end

  for (genvar k = 0; k < MW; k++) begin : g_div
    logic [DW:0] rs, diff;
    logic        ge;
    always_comb begin
      rs   = {dr[k], dl[k][MW-1]};
      diff = rs - {1'b0, dt[k].den};
      ge   = (rs >= {1'b0, dt[k].den});
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (adv) begin
        dv[k+1] <= dv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dr[k+1] <= ge ? diff[DW-1:0] : rs[DW-1:0];
        dl[k+1] <= {dl[k][MW-2:0], 1'b0};
        dq[k+1] <= {dq[k][MW-2:0], ge};
        dt[k+1] <= dt[k];
      end
    end
  end

  logic quiet;
  assign quiet = dt[MW].cnt_err || dt[MW].zero_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv[MW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      count_error         <= dt[MW].cnt_err;
      magnitude_saturated <= !quiet && dt[MW].sat;
      phase_degrees       <= quiet ? '0 : dt[MW].phase;
      if (quiet) begin
        magnitude_volts <= '0;
      end else if (dt[MW].sat) begin
        magnitude_volts <= '1;
      end else begin
        magnitude_volts <= dq[MW];
      end
    end
  end
endmodule

>>> rtl/core/lockin_magnitude_phase.sv
// Top level of the lock-in magnitude/phase block.
//
// Input word: signed in-phase and quadrature sums plus the sample count of
// one lock-in run. Output word: magnitude in volts (unsigned Q8.24,
// saturating), phase atan2(Q, I) in degrees (signed Q.16), a zero-count
// error flag and a saturation flag.
// Both channels are valid/ready; a word moves when both are high.
// The datapath is one pipeline of CORDIC_STAGES + 38 registers (62 at the
// default 24 stages): two front stages (fold, divisor product), one CORDIC
// micro-rotation per stage, gain multiply, product sum, overflow check, one
// restoring-divider stage per magnitude bit, then the output register.
// A new word is taken every cycle unless the output stalls; the divider and
// CORDIC stages are fully pipelined, so throughput is one word per clock.
// The whole pipeline advances together: while the output register holds an
// untaken word, every stage holds and in_stream.ready is low.
// gain_write loads the Q16 calibration gain from gain_data; write it only
// while no word is in flight.
// Synchronous reset empties the pipeline and restores the gain to ~508/478.
module lockin_magnitude_phase (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       gain_write,
  input  logic [lmp_pkg::GAIN_W-1:0] gain_data,
  lmp_in_if.sink                     in_stream,
  lmp_out_if.source                  out_stream
);
  logic                      adv;
  logic [lmp_pkg::GAIN_W-1:0] gain;

  logic              f_valid, c_valid;
  lmp_pkg::lmp_vec_t f_vec, c_vec;

  // single pipeline enable: move whenever the output slot is free or drains
  assign adv             = !out_stream.valid || out_stream.ready;
  assign in_stream.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= lmp_pkg::GAIN_RESET;
    end else if (gain_write) begin
      gain <= gain_data;
    end
  end

  lmp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .in_valid       (in_stream.valid),
    .in_phase_sum   (in_stream.in_phase_sum),
    .quadrature_sum (in_stream.quadrature_sum),
    .sample_count   (in_stream.sample_count),
    .out_valid      (f_valid),
    .out_vec        (f_vec)
  );

  lmp_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_vec    (f_vec),
    .out_valid (c_valid),
    .out_vec   (c_vec)
  );

  lmp_scale u_scale (
    .clk                 (clk),
    .rst                 (rst),
    .adv                 (adv),
    .in_valid            (c_valid),
    .in_vec              (c_vec),
    .gain                (gain),
    .out_valid           (out_stream.valid),
    .magnitude_volts     (out_stream.magnitude_volts),
    .phase_degrees       (out_stream.phase_degrees),
    .count_error         (out_stream.count_error),
    .magnitude_saturated (out_stream.magnitude_saturated)
  );

  // zero count forces an all-zero result
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_stream.valid && out_stream.count_error |->
      out_stream.magnitude_volts == 32'd0 && out_stream.phase_degrees == 25'sd0 &&
      !out_stream.magnitude_saturated)
    else $error("count error word carries nonzero data");

  // clamp reports full scale and never coexists with a count error
  a_sat_full: assert property (@(posedge clk) disable iff (rst)
    out_stream.valid && out_stream.magnitude_saturated |->
      out_stream.magnitude_volts == 32'hFFFF_FFFF && !out_stream.count_error)
    else $error("saturated magnitude not at full scale");

  // phase stays inside +-180 degrees
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_stream.valid |->
      out_stream.phase_degrees <= 25'sd11796480 &&
      out_stream.phase_degrees >= -25'sd11796480)
    else $error("phase out of range");
endmodule

>>> dv/lockin_magnitude_phase_tb.sv
// Self-checking testbench for lockin_magnitude_phase: queued driver, monitor, bit-exact predictor.
`timescale 1ns / 100ps

module lockin_magnitude_phase_tb;
  import lmp_pkg::*;

  typedef struct {
    logic signed [63:0] i_sum;
    logic signed [63:0] q_sum;
    logic [31:0]        count;
  } lockin_word_t;

  typedef struct {
    logic [31:0]        mag;
    logic signed [24:0] phase;
    logic               cnt_err;
    logic               sat;
  } polar_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic gain_write = 1'b0;
  logic [GAIN_W-1:0] gain_data = '0;

  lmp_in_if  in_if();
  lmp_out_if out_if();

  lockin_magnitude_phase dut (
    .clk        (clk),
    .rst        (rst),
    .gain_write (gain_write),
    .gain_data  (gain_data),
    .in_stream  (in_if),
    .out_stream (out_if)
  );

  // Predictor state: our own copy of the gain register and the fixed tables.
  logic [GAIN_W-1:0] model_gain = GAIN_RESET;
  longint            atan_q32 [CORDIC_STAGES];
  logic [63:0]       cordic_k_q31;

  lockin_word_t pending_words[$];
  polar_word_t  expected_polar[$];

  int  errors = 0;
  int  words_in = 0, words_out = 0, zero_counts = 0, sat_count = 0, gain_settings = 0;
  int  idle_cycles = 0;
  int  gap_in = 0, gap_out = 0;
  bit  calm = 0;                  // stretch with no gaps on either side
  logic in_took = 1'b0;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 80;   // pipeline is 62 deep

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.in_phase_sum = '0;
    in_if.quadrature_sum = '0;
    in_if.sample_count = '0;
    out_if.ready = 1'b0;
  end

  // Angle ROM (degrees Q32) and CORDIC gain (Q31) built from the series definition.
  task automatic build_cordic_tables();
    longint      sum;
    logic [63:0] term, rad, prod, p, res, bitv;
    int          e;
    for (int s = 0; s < CORDIC_STAGES; s++) begin
      if (s == 0) begin
        atan_q32[s] = 64'd45 << 32;
      end else begin
        sum = 0;
        for (int k = 0; k < 64; k++) begin
          e = 60 - s * (2 * k + 1);
          if (e < 0) break;
          term = (64'd1 << e) / 64'(2 * k + 1);
          sum = k[0] ? sum - longint'(term) : sum + longint'(term);
        end
        rad = 64'(sum) >> 28;
        prod = rad * 64'd3845054675;
        atan_q32[s] = longint'(prod >> 26);
      end
    end
    p = 64'd1 << 62;
    for (int s = 0; s < CORDIC_STAGES; s++)
      if (2 * s < 64) p = p + (p >> (2 * s));
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > p) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (p >= res + bitv) begin
        p = p - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    cordic_k_q31 = res;
  endtask

  // Expected polar word for one lock-in word under the given gain.
  function automatic polar_word_t predict_polar(lockin_word_t w, logic [GAIN_W-1:0] g);
    polar_word_t  r;
    longint       x, y, z, dx, dy, ph;
    logic [127:0] num, q;
    r.mag = '0;
    r.phase = '0;
    r.cnt_err = 1'b0;
    r.sat = 1'b0;
    if (w.count == 0) begin
      r.cnt_err = 1'b1;
      return r;
    end
    x = w.i_sum >>> 2;
    y = w.q_sum >>> 2;
    if (x == 0 && y == 0) return r;
    z = 0;
    // Left half-plane: fold by 180 degrees, sign taken from y.
    if (x < 0) begin
      z = longint'(64'd180 << 32);
      if (y < 0) z = -z;
      x = -x;
      y = -y;
    end
    for (int s = 0; s < CORDIC_STAGES; s++) begin
      dx = y >>> s;
      dy = x >>> s;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + atan_q32[s];
      end else begin
        x = x - dx; y = y + dy; z = z - atan_q32[s];
      end
    end
    ph = (z + 32768) >>> 16;
    if (ph > PHASE_LIMIT) ph = PHASE_LIMIT;
    if (ph < -PHASE_LIMIT) ph = -PHASE_LIMIT;
    r.phase = ph[24:0];
    num = {64'd0, 64'(x)} * {110'd0, g};
    num = num << NUM_SHIFT;
    q = num / {64'd0, cordic_k_q31};
    q = q / ({96'd0, w.count} * 128'(REF_AMPLITUDE));
    if (q > 128'hFFFF_FFFF) begin
      r.mag = 32'hFFFF_FFFF;
      r.sat = 1'b1;
    end else begin
      r.mag = q[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    errors++;
    $display("mismatch on result %0d, %s: got %0d expected %0d", words_out, field, got, want);
  endtask

  // Mostly short gaps, a few long ones, none during a calm stretch.
  function automatic int next_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] random_sum();
    logic [63:0] v;
    int sel;
    v = {$urandom, $urandom};
    sel = $urandom_range(0, 9);
    if (sel < 3) return v;                               // full width, every bit toggles
    if (sel < 8) return 64'($signed(v) >>> $urandom_range(8, 60));
    return 64'($signed(v) >>> 62);                       // tiny: 0 or -1 area
  endfunction

  function automatic lockin_word_t random_word();
    lockin_word_t w;
    int sel;
    w.i_sum = random_sum();
    w.q_sum = random_sum();
    sel = $urandom_range(0, 19);
    if (sel == 0) w.count = '0;
    else if (sel < 11) w.count = $urandom_range(1, 1000);
    else if (sel < 13) w.count = 32'hFFFF_FFFF;
    else w.count = $urandom;
    if ($urandom_range(0, 15) == 0) w.q_sum = 0;          // on the real axis
    if ($urandom_range(0, 15) == 0) w.i_sum = 0;          // on the imaginary axis
    return w;
  endfunction

  function automatic lockin_word_t make_word(logic [63:0] i_v, logic [63:0] q_v, logic [31:0] n);
    lockin_word_t w;
    w.i_sum = i_v;
    w.q_sum = q_v;
    w.count = n;
    return w;
  endfunction

  // Driver: next word or a gap once the current word has been taken.
  always @(negedge clk) begin
    lockin_word_t w;
    if (!rst && (!in_if.valid || in_took)) begin
      if (gap_in > 0) begin
        gap_in--;
        in_if.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        in_if.in_phase_sum   <= w.i_sum;
        in_if.quadrature_sum <= w.q_sum;
        in_if.sample_count   <= w.count;
        in_if.valid <= 1'b1;
        gap_in = next_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Sink back-pressure.
  always @(negedge clk) begin
    if (!rst) begin
      if (gap_out > 0) begin
        gap_out--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) gap_out = next_gap();
      end
      if ($urandom_range(0, 299) == 0) calm = ~calm;
    end
  end

  // Monitor: predict on input handshake, compare on output handshake.
  always @(posedge clk) begin
    lockin_word_t w;
    polar_word_t  want;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        w.i_sum = in_if.in_phase_sum;
        w.q_sum = in_if.quadrature_sum;
        w.count = in_if.sample_count;
        want = predict_polar(w, model_gain);
        expected_polar.push_back(want);
        words_in++;
        if (want.cnt_err) zero_counts++;
        if (want.sat) sat_count++;
      end
      if (out_if.valid && out_if.ready) begin
        words_out++;
        if (expected_polar.size() == 0) begin
          errors++;
          $display("unexpected result word %0d", words_out);
        end else begin
          want = expected_polar.pop_front();
          if (out_if.magnitude_volts !== want.mag)
            report_mismatch("magnitude_volts", out_if.magnitude_volts, want.mag);
          if (out_if.phase_degrees !== want.phase)
            report_mismatch("phase_degrees", out_if.phase_degrees, want.phase);
          if (out_if.count_error !== want.cnt_err)
            report_mismatch("count_error", out_if.count_error, want.cnt_err);
          if (out_if.magnitude_saturated !== want.sat)
            report_mismatch("magnitude_saturated", out_if.magnitude_saturated, want.sat);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_if.valid || expected_polar.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_gain(logic [GAIN_W-1:0] g);
    @(negedge clk);
    gain_write <= 1'b1;
    gain_data  <= g;
    @(negedge clk);
    gain_write <= 1'b0;
    model_gain = g;
    gain_settings++;
  endtask

  logic [GAIN_W-1:0] gain_plan [6];

  initial begin
    build_cordic_tables();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset gain.
    pending_words.push_back(make_word(64'd1000, 64'd1000, 32'd0));          // zero count
    pending_words.push_back(make_word(64'd0, 64'd0, 32'd5));                 // zero vector
    pending_words.push_back(make_word(64'd3, -64'sd2, 32'd1));               // in-phase zero after shift, quadrature -1
    pending_words.push_back(make_word(64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 32'd1));
    pending_words.push_back(make_word(64'h8000_0000_0000_0000, 64'd0, 32'd1));
    pending_words.push_back(make_word(64'h8000_0000_0000_0000,
                                      64'h8000_0000_0000_0000, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(64'h7FFF_FFFF_FFFF_FFFF,
                                      64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(-64'sd4000, 64'd0, 32'd1));            // negative real axis
    pending_words.push_back(make_word(-64'sd4000, 64'd4, 32'd1));            // just below 180
    pending_words.push_back(make_word(-64'sd4000, -64'sd4, 32'd1));          // just above -180
    pending_words.push_back(make_word(64'd0, 64'd40000, 32'd3));             // +90
    pending_words.push_back(make_word(64'd0, -64'sd40000, 32'd3));           // -90
    pending_words.push_back(make_word(64'd1 << 50, 64'd1 << 50, 32'd1));      // saturates
    pending_words.push_back(make_word(64'd1 << 40, -64'sd1 << 40, 32'd1000));
    pending_words.push_back(make_word(-64'sd1 << 45, 64'd1 << 30, 32'd77));
    pending_words.push_back(make_word(64'hFFFF_FFFF_FFFF_FFFF, 64'd8, 32'd2));
    wait_drained();

    gain_plan[0] = GAIN_RESET;
    gain_plan[1] = '0;
    gain_plan[2] = 18'h3FFFF;
    gain_plan[3] = 18'd65536;
    gain_plan[4] = $urandom_range(1, 262142);
    gain_plan[5] = 18'd1;
    foreach (gain_plan[p]) begin
      write_gain(gain_plan[p]);
      if (p == 2) begin
        // Largest gain on the extreme vectors.
        pending_words.push_back(make_word(64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 32'd1));
        pending_words.push_back(make_word(64'h8000_0000_0000_0000,
                                          64'h8000_0000_0000_0000, 32'd1));
      end
      for (int k = 0; k < 215; k++) pending_words.push_back(random_word());
      wait_drained();
    end

    $display("checked %0d result words over %0d gain settings", words_out, gain_settings + 1);
    $display("%0d zero-count words, %0d saturated magnitudes, %0d mismatches",
             zero_counts, sat_count, errors);
    if (errors == 0 && expected_polar.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
